// ----- hw/rtl/root_locator_polynomial_engine_assert.svh -----
// Assertion macros for the root locator polynomial engine.
`ifndef ROOT_LOCATOR_POLYNOMIAL_ENGINE_ASSERT_SVH
`define ROOT_LOCATOR_POLYNOMIAL_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define RLPE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RLPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RLPE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define RLPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/rlpe_pkg.sv -----
// Package: field constants, arithmetic helpers, opcodes, states and control structs.
package rlpe_pkg;

    localparam int MAX_DEGREE  = 64;
    localparam int STORE_DEPTH = MAX_DEGREE + 1;
    localparam int DEG_W       = $clog2(STORE_DEPTH);
    localparam int ELEM_W      = 31;
    localparam int PROD_W      = 2 * ELEM_W;
    localparam int OP_W        = 2;

    localparam logic [ELEM_W-1:0] FIELD_PRIME = {ELEM_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR    = 2'd0,
        OP_ADD_ROOT = 2'd1,
        OP_EVAL     = 2'd2
    } t_opcode;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CLR,
        S_RD,
        S_MUL,
        S_RED,
        S_WB,
        S_TOP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic latch;
        logic wr_one;
        logic rd;
        logic step;
        logic mul;
        logic red;
        logic wb;
        logic top;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic last;
        logic is_eval;
    } t_stat;

    // Mersenne fold of a full product, then one conditional subtract.
    function automatic logic [ELEM_W-1:0] fold_reduce(input logic [PROD_W-1:0] v);
        logic [ELEM_W:0] s1;
        logic [ELEM_W:0] s2;
        s1 = {1'b0, v[ELEM_W-1:0]} + {1'b0, v[PROD_W-1:ELEM_W]};
        s2 = {1'b0, s1[ELEM_W-1:0]} + {{ELEM_W{1'b0}}, s1[ELEM_W]};
        if (s2 >= {1'b0, FIELD_PRIME}) begin
            s2 = s2 - {1'b0, FIELD_PRIME};
        end
        return s2[ELEM_W-1:0];
    endfunction

    function automatic logic [ELEM_W-1:0] field_add(input logic [ELEM_W-1:0] a,
                                                    input logic [ELEM_W-1:0] b);
        logic [ELEM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, FIELD_PRIME}) begin
            s = s - {1'b0, FIELD_PRIME};
        end
        return s[ELEM_W-1:0];
    endfunction

    function automatic logic [ELEM_W-1:0] field_sub(input logic [ELEM_W-1:0] a,
                                                    input logic [ELEM_W-1:0] b);
        logic [ELEM_W:0] t;
        t = {1'b0, a} + {1'b0, FIELD_PRIME} - {1'b0, b};
        if (a >= b) begin
            return a - b;
        end
        return t[ELEM_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/rlpe_channels.sv -----
// Valid/ready channel interfaces for command words and result words.
interface rlpe_in_if;
    logic                        valid;
    logic                        ready;
    logic [rlpe_pkg::OP_W-1:0]   opcode;
    logic [rlpe_pkg::ELEM_W-1:0] operand;

    modport source (output valid, output opcode, output operand, input ready);
    modport sink   (input valid, input opcode, input operand, output ready);
endinterface

interface rlpe_out_if;
    logic                        valid;
    logic                        ready;
    logic [rlpe_pkg::ELEM_W-1:0] value;
    logic [rlpe_pkg::DEG_W-1:0]  degree;
    logic                        status;

    modport source (output valid, output value, output degree, output status, input ready);
    modport sink   (input valid, input value, input degree, input status, output ready);
endinterface

// ----- hw/rtl/rlpe_ram.sv -----
// Generic single write port, single read port RAM with registered read.
module rlpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hw/rtl/rlpe_dpath.sv -----
// Datapath: coefficient store, shared modular multiplier, accumulator and result register.
module rlpe_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rlpe_pkg::t_cmd              i_cmd,
    output rlpe_pkg::t_stat             o_stat,
    input  logic [rlpe_pkg::OP_W-1:0]   i_opcode,
    input  logic [rlpe_pkg::ELEM_W-1:0] i_operand,
    output logic [rlpe_pkg::ELEM_W-1:0] o_value,
    output logic [rlpe_pkg::DEG_W-1:0]  o_degree,
    output logic                        o_status
);
    import rlpe_pkg::*;

    logic [DEG_W-1:0]  r_degree;
    logic [DEG_W-1:0]  r_idx;
    logic              r_is_eval;
    logic              r_status;
    logic [ELEM_W-1:0] r_arg;
    logic [ELEM_W-1:0] r_acc;
    logic [ELEM_W-1:0] r_prev;
    logic [ELEM_W-1:0] r_coef;
    logic [PROD_W-1:0] r_prod;
    logic [ELEM_W-1:0] r_red;
    logic [ELEM_W-1:0] r_out_value;
    logic [DEG_W-1:0]  r_out_degree;
    logic              r_out_status;

    logic              full;
    logic [DEG_W-1:0]  idx_step;
    logic [ELEM_W-1:0] arg_in;
    logic [ELEM_W-1:0] mul_b;
    logic [ELEM_W-1:0] rd_data;
    logic              ram_we;
    logic [DEG_W-1:0]  ram_waddr;
    logic [ELEM_W-1:0] ram_wdata;
    logic [DEG_W-1:0]  ram_raddr;

    assign full     = (r_degree >= DEG_W'(MAX_DEGREE));
    assign idx_step = r_is_eval ? (r_idx - DEG_W'(1)) : (r_idx + DEG_W'(1));
    // An operand equal to the prime acts as zero.
    assign arg_in   = (i_operand == FIELD_PRIME) ? '0 : i_operand;
    assign mul_b    = r_is_eval ? r_acc : rd_data;

    assign o_stat.full    = full;
    assign o_stat.is_eval = r_is_eval;
    assign o_stat.last    = r_is_eval ? (r_idx == '0) : (r_idx == r_degree);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = field_sub(r_prev, r_red);
        if (i_cmd.wr_one) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = ELEM_W'(1);
        end else if (i_cmd.top) begin
            // Old leading coefficient moves up one place.
            ram_we    = 1'b1;
            ram_waddr = r_degree + DEG_W'(1);
            ram_wdata = r_prev;
        end else if (i_cmd.wb && !r_is_eval) begin
            ram_we    = 1'b1;
        end
    end

    assign ram_raddr = i_cmd.step ? idx_step : r_idx;

    rlpe_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= '0;
        end else if (i_cmd.wr_one) begin
            r_degree <= '0;
        end else if (i_cmd.top) begin
            r_degree <= r_degree + DEG_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_is_eval <= (i_opcode == OP_EVAL);
            r_status  <= (i_opcode == OP_ADD_ROOT) && full;
            r_arg     <= arg_in;
            r_acc     <= '0;
            r_prev    <= '0;
            r_idx     <= (i_opcode == OP_EVAL) ? r_degree : '0;
        end
        if (i_cmd.step) begin
            r_idx <= idx_step;
        end
        if (i_cmd.mul) begin
            r_coef <= rd_data;
            r_prod <= {{ELEM_W{1'b0}}, r_arg} * {{ELEM_W{1'b0}}, mul_b};
        end
        if (i_cmd.red) begin
            r_red <= fold_reduce(r_prod);
        end
        if (i_cmd.wb) begin
            if (r_is_eval) begin
                r_acc <= field_add(r_red, r_coef);
            end else begin
                r_prev <= r_coef;
            end
        end
        if (i_cmd.load_out) begin
            r_out_value  <= r_acc;
            r_out_degree <= r_degree;
            r_out_status <= r_status;
        end
    end

    assign o_value  = r_out_value;
    assign o_degree = r_out_degree;
    assign o_status = r_out_status;
endmodule

// ----- hw/rtl/rlpe_ctrl.sv -----
// Controller: sequences clear, add-root and evaluate over the coefficient store.
module rlpe_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [rlpe_pkg::OP_W-1:0] i_opcode,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output rlpe_pkg::t_cmd            o_cmd,
    input  rlpe_pkg::t_stat           i_stat
);
    import rlpe_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.wr_one = 1'b1;
                n_state      = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    case (i_opcode)
                        OP_CLEAR:    n_state = S_CLR;
                        OP_ADD_ROOT: n_state = i_stat.full ? S_DONE : S_RD;
                        OP_EVAL:     n_state = S_RD;
                        default:     n_state = S_DONE;
                    endcase
                end
            end
            S_CLR: begin
                o_cmd.wr_one = 1'b1;
                n_state      = S_DONE;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_RED;
            end
            S_RED: begin
                o_cmd.red = 1'b1;
                n_state   = S_WB;
            end
            S_WB: begin
                o_cmd.wb = 1'b1;
                if (i_stat.last) begin
                    n_state = i_stat.is_eval ? S_DONE : S_TOP;
                end else begin
                    // Fetch the next coefficient while this one is written back.
                    o_cmd.rd   = 1'b1;
                    o_cmd.step = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_TOP: begin
                o_cmd.top = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                // Hold until the result register is free.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

// ----- hw/rtl/root_locator_polynomial_engine.sv -----
// From accepted word to result, d = degree: clear runs S_CLR then S_DONE; a refused root or unused
// code goes straight to S_DONE; evaluate and add-root run S_RD, then S_MUL, S_RED and S_WB for each
// of the d+1 coefficients around the single shared 31x31 multiplier and its fold stage, add-root
// ending in S_TOP; the next word is taken back in S_IDLE. The store is one RAM with one write and
// one registered read port. Reset (synchronous, active low) clears degree and control; the S_INIT
// state after reset writes coefficient zero to one, with ready low.
`include "root_locator_polynomial_engine_assert.svh"

module root_locator_polynomial_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rlpe_in_if.sink     i_in,
    rlpe_out_if.source  o_out
);
    import rlpe_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    rlpe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_opcode    (i_in.opcode),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    rlpe_dpath u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .i_opcode  (i_in.opcode),
        .i_operand (i_in.operand),
        .o_value   (o_out.value),
        .o_degree  (o_out.degree),
        .o_status  (o_out.status)
    );

    `RLPE_ASSERT_NOW(a_refused_at_full, i_clk, i_rst_n, o_out.valid && o_out.status,
        (o_out.degree == DEG_W'(MAX_DEGREE)) && (o_out.value == '0),
        "refused root without full degree or with nonzero value")
    `RLPE_ASSERT_NOW(a_degree_bound, i_clk, i_rst_n, o_out.valid,
        o_out.degree <= DEG_W'(MAX_DEGREE), "degree beyond maximum")
    `RLPE_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in.valid && i_in.ready,
        !i_in.ready, "new word taken while previous one is in flight")
endmodule
